// ===== rtl/bitu_pkg.sv =====
// ----------------------------------------------------------------------------
// bitu_pkg: shared types and constants of the MSB-first bit unpacker
// Transaction payloads, command record, operation and status codes, defaults.
// ----------------------------------------------------------------------------
package bitu_pkg;

  localparam int BUFFER_BITS_DEF = 64;
  localparam int MAX_READ_DEF    = 32;

  localparam int UNIT_WIDTH_W = 6;
  localparam int UNIT_WIDTH_MAX = 32;
  localparam logic [UNIT_WIDTH_W-1:0] UNIT_WIDTH_RST = 6'd8;
  localparam int BYTE_W = 8;

  localparam int READ_BITS_W = 32;
  localparam int COUNT_W     = 6;
  localparam int POSITION_W  = 32;
  localparam int BUFFERED_W  = 7;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [BYTE_W-1:0]  unit_data;
    logic [COUNT_W-1:0] read_count;
  } in_item_t;

  typedef struct packed {
    logic [READ_BITS_W-1:0] read_bits;
    logic [COUNT_W-1:0]     bits_returned;
    logic [1:0]             status;
    logic [POSITION_W-1:0]  bit_position;
    logic [BUFFERED_W-1:0]  bits_buffered;
  } out_item_t;

  // classified command: amount is the clamped width for a push or count for a read
  typedef struct packed {
    logic [1:0]         operation;
    logic [COUNT_W-1:0] amount;
    logic [BYTE_W-1:0]  unit;
  } cmd_t;

endpackage

// ===== rtl/msb_first_bit_unpacker.sv =====
// ----------------------------------------------------------------------------
// msb_first_bit_unpacker: MSB-first bit-stream unpacker
// Push units into a bit buffer, read the oldest bits MSB-first, restart.
// ----------------------------------------------------------------------------
// One transaction per clock cycle, sustained, in both directions, while
// neither queue is full. Every accepted item gives exactly one result: the
// item is registered into the two-entry command queue, executed by the
// execution stage's barrel shift, and its result registered into the
// two-entry result queue, where it is poppable. Write unit_width only while no
// result is outstanding. A push that would overfill the buffer is dropped with
// overflow status; a read of more bits than are buffered returns underflow and
// consumes nothing.
module msb_first_bit_unpacker #(
  parameter int BUFFER_BITS = bitu_pkg::BUFFER_BITS_DEF,
  parameter int MAX_READ    = bitu_pkg::MAX_READ_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  bitu_pkg::in_item_t                in_data,
  output logic                              empty,
  input  logic                              pop,
  output bitu_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bitu_pkg::UNIT_WIDTH_W-1:0] cfg_data
);

  bitu_pkg::cmd_t      cmd_in;
  bitu_pkg::cmd_t      cmd_out;
  bitu_pkg::out_item_t res;
  logic                cmd_empty;
  logic                cmd_pop;
  logic                res_full;
  logic                res_push;

  bitu_front #(
    .MAX_READ (MAX_READ)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .item      (in_data),
    .cmd       (cmd_in)
  );

  bitu_fifo #(
    .WIDTH ($bits(bitu_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  bitu_back #(
    .BUFFER_BITS (BUFFER_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  bitu_fifo #(
    .WIDTH ($bits(bitu_pkg::out_item_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

endmodule

// ===== rtl/bitu_fifo.sv =====
// ----------------------------------------------------------------------------
// bitu_fifo: small register queue
// Holds up to DEPTH entries; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module bitu_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    empty |-> wr_ptr == rd_ptr)
    else $error("empty queue with unequal pointers");

endmodule

// ===== rtl/bitu_front.sv =====
// ----------------------------------------------------------------------------
// bitu_front: input classification
// Holds the unit width register, clamps widths and counts, masks the unit.
// ----------------------------------------------------------------------------
module bitu_front #(
  parameter int MAX_READ = bitu_pkg::MAX_READ_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bitu_pkg::UNIT_WIDTH_W-1:0]    cfg_data,
  input  bitu_pkg::in_item_t                   item,
  output bitu_pkg::cmd_t                       cmd
);

  logic [bitu_pkg::UNIT_WIDTH_W-1:0] unit_width;
  logic [bitu_pkg::UNIT_WIDTH_W-1:0] width_eff;
  logic [bitu_pkg::COUNT_W-1:0]      count_eff;
  logic [bitu_pkg::BYTE_W-1:0]       unit_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_width <= bitu_pkg::UNIT_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unit_width <= cfg_data;
    end
  end

  always_comb begin
    if (unit_width == '0) begin
      width_eff = bitu_pkg::UNIT_WIDTH_W'(1);
    end else if (unit_width > bitu_pkg::UNIT_WIDTH_W'(bitu_pkg::UNIT_WIDTH_MAX)) begin
      width_eff = bitu_pkg::UNIT_WIDTH_W'(bitu_pkg::UNIT_WIDTH_MAX);
    end else begin
      width_eff = unit_width;
    end

    if (item.read_count > bitu_pkg::COUNT_W'(MAX_READ)) begin
      count_eff = bitu_pkg::COUNT_W'(MAX_READ);
    end else begin
      count_eff = item.read_count;
    end

    if (width_eff < bitu_pkg::UNIT_WIDTH_W'(bitu_pkg::BYTE_W)) begin
      unit_mask = ~({bitu_pkg::BYTE_W{1'b1}} << width_eff);
    end else begin
      unit_mask = {bitu_pkg::BYTE_W{1'b1}};
    end

    cmd.operation = item.operation;
    cmd.unit      = item.unit_data & unit_mask;
    cmd.amount    = (item.operation == bitu_pkg::OP_PUSH) ? width_eff : count_eff;
  end

endmodule

// ===== rtl/bitu_back.sv =====
// ----------------------------------------------------------------------------
// bitu_back: command execution
// Bit buffer, fill level and position; one command per cycle via barrel shift while the result queue is not full.
// ----------------------------------------------------------------------------
module bitu_back #(
  parameter int BUFFER_BITS = bitu_pkg::BUFFER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  bitu_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output bitu_pkg::out_item_t res
);

  localparam int FILL_W = $clog2(BUFFER_BITS + 1);

  logic [BUFFER_BITS-1:0]          bit_buffer;
  logic [BUFFER_BITS-1:0]          bit_buffer_next;
  logic [FILL_W-1:0]               fill_level;
  logic [FILL_W-1:0]               fill_level_next;
  logic [bitu_pkg::POSITION_W-1:0] consumed_count;
  logic [bitu_pkg::POSITION_W-1:0] consumed_count_next;
  logic [FILL_W:0]                 fill_sum;
  logic [FILL_W-1:0]               amount_ext;
  logic [BUFFER_BITS-1:0]          shifted;
  logic [bitu_pkg::READ_BITS_W-1:0] read_mask;
  logic                            go;

  assign go       = cmd_valid && !res_full;
  assign cmd_pop  = go;
  assign res_push = go;

  assign amount_ext = FILL_W'(cmd.amount);
  assign fill_sum   = {1'b0, fill_level} + (FILL_W + 1)'(cmd.amount);
  assign shifted    = bit_buffer >> (fill_level - amount_ext);
  assign read_mask  = ~({bitu_pkg::READ_BITS_W{1'b1}} << cmd.amount);

  always_comb begin
    bit_buffer_next     = bit_buffer;
    fill_level_next     = fill_level;
    consumed_count_next = consumed_count;
    res.read_bits       = '0;
    res.bits_returned   = '0;
    res.status          = bitu_pkg::ST_OK;

    unique case (cmd.operation)
      bitu_pkg::OP_PUSH: begin
        if (fill_sum > (FILL_W + 1)'(BUFFER_BITS)) begin
          res.status = bitu_pkg::ST_OVERFLOW;
        end else begin
          bit_buffer_next = (bit_buffer << cmd.amount) | BUFFER_BITS'(cmd.unit);
          fill_level_next = fill_sum[FILL_W-1:0];
        end
      end
      bitu_pkg::OP_READ: begin
        if (amount_ext > fill_level) begin
          res.status = bitu_pkg::ST_UNDERFLOW;
        end else begin
          res.read_bits       = shifted[bitu_pkg::READ_BITS_W-1:0] & read_mask;
          res.bits_returned   = cmd.amount;
          fill_level_next     = fill_level - amount_ext;
          consumed_count_next = consumed_count
                                + bitu_pkg::POSITION_W'(cmd.amount);
        end
      end
      bitu_pkg::OP_RESTART: begin
        bit_buffer_next     = '0;
        fill_level_next     = '0;
        consumed_count_next = '0;
      end
      default: begin
      end
    endcase

    res.bit_position  = consumed_count_next;
    res.bits_buffered = bitu_pkg::BUFFERED_W'(fill_level_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer     <= '0;
      fill_level     <= '0;
      consumed_count <= '0;
    end else if (go) begin
      bit_buffer     <= bit_buffer_next;
      fill_level     <= fill_level_next;
      consumed_count <= consumed_count_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= FILL_W'(BUFFER_BITS))
    else $error("fill level beyond buffer size");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    go && cmd.operation == bitu_pkg::OP_RESTART
    |=> fill_level == '0 && consumed_count == '0)
    else $error("restart left state behind");

  a_refused_keeps: assert property (@(posedge clk) disable iff (rst)
    go && res.status != bitu_pkg::ST_OK |=> $stable(fill_level)
    && $stable(consumed_count))
    else $error("refused transaction changed state");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(fill_level) && $stable(consumed_count))
    else $error("state moved without a command");

endmodule

// ===== verif/tb_msb_first_bit_unpacker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_msb_first_bit_unpacker: self-checking testbench of the MSB-first unpacker
// A table of directed pushes, reads and restarts is followed by random phases,
// each under its own unit width. Every result popped is checked field by field
// against the table's literal result or a predictor of the bit buffer, fill level and position.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_unpacker;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES     = 9;
  localparam int PHASE_LEN  = 200;

  typedef struct {
    bit                  is_cfg;
    logic [5:0]          cfg_val;
    bitu_pkg::in_item_t  item;
    bit                  has_lit;
    bitu_pkg::out_item_t lit;
  } step_row_t;

  logic                default_unused_guard;
  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  bitu_pkg::in_item_t  in_data;
  logic                empty;
  logic                pop;
  bitu_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [bitu_pkg::UNIT_WIDTH_W-1:0] cfg_data;

  logic [bitu_pkg::BUFFER_BITS_DEF-1:0] stream_bits;
  int                                   stream_fill;
  logic [bitu_pkg::POSITION_W-1:0]      stream_pos;
  logic [bitu_pkg::UNIT_WIDTH_W-1:0]    unit_w;

  bitu_pkg::out_item_t pending_results[$];
  step_row_t           steps[$];
  int                  err_cnt;
  int                  push_idle_pct;
  int                  pop_idle_pct;
  int                  hold_req;

  msb_first_bit_unpacker u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  function automatic bitu_pkg::out_item_t unpack_step(input bitu_pkg::in_item_t it);
    bitu_pkg::out_item_t r;
    int        w;
    int        n;
    logic [bitu_pkg::BUFFER_BITS_DEF-1:0] unit;
    r = '0;
    case (it.operation)
      bitu_pkg::OP_PUSH: begin
        w = (unit_w == 0) ? 1 : ((unit_w > bitu_pkg::UNIT_WIDTH_MAX)
                                 ? bitu_pkg::UNIT_WIDTH_MAX : int'(unit_w));
        if (stream_fill + w > bitu_pkg::BUFFER_BITS_DEF) begin
          r.status = bitu_pkg::ST_OVERFLOW;
        end else begin
          unit = {{(bitu_pkg::BUFFER_BITS_DEF-bitu_pkg::BYTE_W){1'b0}}, it.unit_data};
          if (w < bitu_pkg::BYTE_W) unit = unit & ((64'd1 << w) - 64'd1);
          stream_bits = (stream_bits << w) | unit;
          stream_fill += w;
        end
      end
      bitu_pkg::OP_READ: begin
        n = (it.read_count > bitu_pkg::MAX_READ_DEF) ? bitu_pkg::MAX_READ_DEF
                                                     : int'(it.read_count);
        if (n > stream_fill) begin
          r.status = bitu_pkg::ST_UNDERFLOW;
        end else if (n > 0) begin
          r.read_bits = 32'((stream_bits >> (stream_fill - n)) & ((64'd1 << n) - 64'd1));
          r.bits_returned = 6'(n);
          stream_fill -= n;
          stream_pos += 32'(n);
        end
      end
      bitu_pkg::OP_RESTART: begin
        stream_bits = '0;
        stream_fill = 0;
        stream_pos = '0;
      end
      default: ;
    endcase
    r.bit_position = stream_pos;
    r.bits_buffered = 7'(stream_fill);
    return r;
  endfunction

  function automatic step_row_t op_row(input logic [1:0] op, input logic [7:0] data,
                                       input logic [5:0] cnt);
    step_row_t s;
    s = '{is_cfg: 1'b0, cfg_val: '0, item: '0, has_lit: 1'b0, lit: '0};
    s.item.operation = op;
    s.item.unit_data = data;
    s.item.read_count = cnt;
    return s;
  endfunction

  function automatic step_row_t lit_row(input logic [1:0] op, input logic [7:0] data,
                                        input logic [5:0] cnt, input logic [31:0] bits,
                                        input logic [5:0] got, input logic [1:0] st,
                                        input logic [31:0] pos, input logic [6:0] buffered);
    step_row_t s;
    s = op_row(op, data, cnt);
    s.has_lit = 1'b1;
    s.lit = '{read_bits: bits, bits_returned: got, status: st, bit_position: pos,
              bits_buffered: buffered};
    return s;
  endfunction

  function automatic step_row_t cfg_row(input logic [5:0] v);
    step_row_t s;
    s = '{is_cfg: 1'b1, cfg_val: v, item: '0, has_lit: 1'b0, lit: '0};
    return s;
  endfunction

  function automatic bitu_pkg::in_item_t random_item();
    bitu_pkg::in_item_t it;
    int       pick;
    int       room;
    it.operation = bitu_pkg::OP_PUSH;
    it.unit_data = 8'($urandom);
    it.read_count = 6'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      it.operation = bitu_pkg::OP_PUSH;
    end else if (pick < 85) begin
      it.operation = bitu_pkg::OP_READ;
      room = (stream_fill > bitu_pkg::MAX_READ_DEF) ? bitu_pkg::MAX_READ_DEF : stream_fill;
      it.read_count = 6'($urandom_range(room));
    end else if (pick < 93) begin
      it.operation = bitu_pkg::OP_READ;
    end else if (pick < 97) begin
      it.operation = bitu_pkg::OP_RESTART;
    end else begin
      it.operation = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic add_step(input step_row_t s);
    steps.insert(steps.size(), s);
  endtask

  task automatic check_result(input bitu_pkg::out_item_t got,
                              input bitu_pkg::out_item_t want);
    if (got.read_bits !== want.read_bits) begin
      $error("read_bits: expected %h, got %h", want.read_bits, got.read_bits);
      err_cnt++;
    end
    if (got.bits_returned !== want.bits_returned) begin
      $error("bits_returned: expected %0d, got %0d", want.bits_returned, got.bits_returned);
      err_cnt++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      err_cnt++;
    end
    if (got.bit_position !== want.bit_position) begin
      $error("bit_position: expected %0d, got %0d", want.bit_position, got.bit_position);
      err_cnt++;
    end
    if (got.bits_buffered !== want.bits_buffered) begin
      $error("bits_buffered: expected %0d, got %0d", want.bits_buffered, got.bits_buffered);
      err_cnt++;
    end
  endtask

  task automatic send_item(input bitu_pkg::in_item_t it, input bit use_lit,
                           input bitu_pkg::out_item_t lit);
    bitu_pkg::out_item_t predicted;
    in_data <= it;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    predicted = unpack_step(it);
    pending_results.insert(pending_results.size(), use_lit ? lit : predicted);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_width(input logic [bitu_pkg::UNIT_WIDTH_W-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    unit_w = v;
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result popped with no transaction outstanding");
        err_cnt++;
      end else begin
        check_result(out_data, pending_results.pop_front());
      end
    end
  end

  initial begin
    int n;
    pop <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        pop <= ($urandom_range(99) >= pop_idle_pct);
      end
    end
  end

  initial begin
    logic [bitu_pkg::UNIT_WIDTH_W-1:0] phase_width[PHASES];
    rst <= 1'b1;
    push <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    stream_bits = '0;
    stream_fill = 0;
    stream_pos = '0;
    unit_w = bitu_pkg::UNIT_WIDTH_RST;
    err_cnt = 0;
    hold_req = 0;
    push_idle_pct = 37;
    pop_idle_pct = 56;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    add_step(lit_row(bitu_pkg::OP_READ, 8'h00, 6'd0, 32'h0, 6'd0,
                     bitu_pkg::ST_OK, 32'd0, 7'd0));
    add_step(lit_row(bitu_pkg::OP_READ, 8'h00, 6'd1, 32'h0, 6'd0,
                     bitu_pkg::ST_UNDERFLOW, 32'd0, 7'd0));
    add_step(lit_row(bitu_pkg::OP_PUSH, 8'hFF, 6'd0, 32'h0, 6'd0,
                     bitu_pkg::ST_OK, 32'd0, 7'd8));
    add_step(lit_row(bitu_pkg::OP_PUSH, 8'h00, 6'd63, 32'h0, 6'd0,
                     bitu_pkg::ST_OK, 32'd0, 7'd16));
    add_step(lit_row(bitu_pkg::OP_READ, 8'hFF, 6'd63, 32'h0, 6'd0,
                     bitu_pkg::ST_UNDERFLOW, 32'd0, 7'd16));
    add_step(lit_row(bitu_pkg::OP_READ, 8'h00, 6'd16, 32'hFF00, 6'd16,
                     bitu_pkg::ST_OK, 32'd16, 7'd0));
    add_step(lit_row(OP_UNUSED, 8'hAA, 6'd63, 32'h0, 6'd0,
                     bitu_pkg::ST_OK, 32'd16, 7'd0));
    add_step(lit_row(bitu_pkg::OP_RESTART, 8'h55, 6'd5, 32'h0, 6'd0,
                     bitu_pkg::ST_OK, 32'd0, 7'd0));
    repeat (8) add_step(op_row(bitu_pkg::OP_PUSH, 8'hA5, 6'd0));
    add_step(lit_row(bitu_pkg::OP_PUSH, 8'h5A, 6'd0, 32'h0, 6'd0,
                     bitu_pkg::ST_OVERFLOW, 32'd0, 7'd64));
    add_step(lit_row(bitu_pkg::OP_READ, 8'h00, 6'd32, 32'hA5A5A5A5, 6'd32,
                     bitu_pkg::ST_OK, 32'd32, 7'd32));
    add_step(lit_row(bitu_pkg::OP_READ, 8'h00, 6'd32, 32'hA5A5A5A5, 6'd32,
                     bitu_pkg::ST_OK, 32'd64, 7'd0));
    add_step(cfg_row(6'd0));
    add_step(op_row(bitu_pkg::OP_PUSH, 8'hFF, 6'd0));
    add_step(op_row(bitu_pkg::OP_PUSH, 8'hFE, 6'd0));
    add_step(op_row(bitu_pkg::OP_READ, 8'h00, 6'd2));
    add_step(cfg_row(6'd63));
    add_step(op_row(bitu_pkg::OP_PUSH, 8'hFF, 6'd0));
    add_step(op_row(bitu_pkg::OP_PUSH, 8'h80, 6'd0));
    add_step(op_row(bitu_pkg::OP_READ, 8'h00, 6'd32));
    add_step(op_row(bitu_pkg::OP_READ, 8'h00, 6'd32));

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        settle();
        write_width(steps[i].cfg_val);
      end else begin
        send_item(steps[i].item, steps[i].has_lit, steps[i].lit);
      end
    end

    phase_width = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd7, 6'd8, 6'd13, 6'($urandom), 6'($urandom)};
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_width(phase_width[ph]);
      case (ph / 3)
        0: begin
          push_idle_pct = 37;
          pop_idle_pct = 56;
        end
        1: begin
          push_idle_pct = 56;
          pop_idle_pct = 37;
        end
        default: begin
          push_idle_pct = 0;
          pop_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < PHASE_LEN; k++) begin
        if (ph == 1 && k == 60) hold_req = 300;
        if (ph == 4 && k == 100) settle();
        send_item(random_item(), 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== msb_first_bit_unpacker.f =====
rtl/bitu_pkg.sv
rtl/bitu_fifo.sv
rtl/bitu_front.sv
rtl/bitu_back.sv
rtl/msb_first_bit_unpacker.sv
verif/tb_msb_first_bit_unpacker.sv
